@@ rtl/hit_position_dedup_binner_defines.svh @@
// ---------------------------------------------------------------------------
// hit_position_dedup_binner assertion macros
// concurrent checks on clk with rst as disable, removed with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef HIT_POSITION_DEDUP_BINNER_DEFINES_SVH
`define HIT_POSITION_DEDUP_BINNER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define HPDB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define HPDB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HPDB_ASSERT_IMPL(label, ante, cons, msg)
`define HPDB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/hpdb_pkg.sv @@
// ---------------------------------------------------------------------------
// hpdb_pkg
// shared widths, types and helpers of the hit dedup binner
// ---------------------------------------------------------------------------
package hpdb_pkg;

  localparam int POS_W               = 20;
  localparam int WIDTH_W             = 16;
  localparam int BAR_OUT_W           = 10;
  localparam int CENTER_W            = 24;
  localparam int TABLE_DEPTH_DEFAULT = 64;
  localparam int MAX_BINS_DEFAULT    = 256;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [WIDTH_W-1:0]      width_t;

  // one axis handed to the binning unit
  typedef struct packed {
    pos_t   coord;
    width_t width;
    pos_t   lo;
    pos_t   hi;
  } bin_cfg_t;

  typedef struct packed {
    logic                        done;
    logic signed [BAR_OUT_W-1:0] bar;
    logic signed [CENTER_W-1:0]  center;
  } bin_res_t;

  typedef struct packed {
    logic done;
    logic match;
  } scan_res_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

@@ rtl/hit_position_dedup_binner.sv @@
// ---------------------------------------------------------------------------
// hit_position_dedup_binner
// drops repeated hit positions within an event and bins the rest
// ---------------------------------------------------------------------------
// usage
//   s_* channel takes one hit word: x, y, z and an event-start flag in tuser;
//   the flag empties the position table before the hit is looked at
//   m_* channel gives one word per kept hit: position, bar indices, bin
//   centres, and a table-full flag in tuser; a repeated hit gives no word
//   cfg_we/cfg_index/cfg_data write the bin and range registers while idle
// timing
//   one hit at a time: after a kept hit the input frees once its word is
//   loaded into the output register; the scan reads the N stored positions
//   (one table read per cycle), and the shared binning unit finds the BAR_W
//   bits of the bar index (one bit per cycle); a repeat frees the input
//   once the scan stops at the match
// reset
//   registers go to their defaults, table is empty, no word pending
// back-pressure
//   a finished word sits in the output register; the next hit is taken and
//   worked on meanwhile, and only waits at the end if the word is not taken
// ---------------------------------------------------------------------------
`include "hit_position_dedup_binner_defines.svh"

module hit_position_dedup_binner
  import hpdb_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int MAX_BINS    = MAX_BINS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // hit word in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // hit_x, hit_y, hit_z, zero pad
  input  logic [0:0]   s_tuser,   // event_start
  // result word out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // out_x, out_y, out_z, bar_x, bar_y, center_x, center_y
  output logic [0:0]   m_tuser,   // table_full
  // register writes
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [19:0]  cfg_data
);

  localparam int AW = addr_w(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // register map
  localparam logic [2:0] REG_BIN_WIDTH_X     = 3'd0;
  localparam logic [2:0] REG_BIN_WIDTH_Y     = 3'd1;
  localparam logic [2:0] REG_MATCH_TOLERANCE = 3'd2;
  localparam logic [2:0] REG_RANGE_MIN_X     = 3'd3;
  localparam logic [2:0] REG_RANGE_MAX_X     = 3'd4;
  localparam logic [2:0] REG_RANGE_MIN_Y     = 3'd5;
  localparam logic [2:0] REG_RANGE_MAX_Y     = 3'd6;

  localparam width_t RST_BIN_WIDTH = 16'd640;
  localparam width_t RST_TOLERANCE = 16'd64;
  localparam pos_t   RST_RANGE_MIN = -20'sd6400;
  localparam pos_t   RST_RANGE_MAX = 20'sd6400;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_BINX, S_BINY, S_OUT} state_t;

  // configuration
  width_t bin_width_x;
  width_t bin_width_y;
  width_t match_tolerance;
  pos_t   range_min_x;
  pos_t   range_max_x;
  pos_t   range_min_y;
  pos_t   range_max_y;

  // control and working registers
  state_t        state;
  logic [CW-1:0] count;
  logic          scan_start;
  logic          bin_start;
  logic          axis_y;
  pos_t          hit_x;
  pos_t          hit_y;
  pos_t          hit_z;
  logic          full;
  logic signed [BAR_OUT_W-1:0] bar_x;
  logic signed [CENTER_W-1:0]  center_x;
  logic signed [BAR_OUT_W-1:0] bar_y;
  logic signed [CENTER_W-1:0]  center_y;

  // interconnect
  logic [AW-1:0]      raddr;
  logic [2*POS_W-1:0] rdata;
  scan_res_t          scan_res;
  bin_res_t           bin_res;
  bin_cfg_t           bin_cfg;
  logic               store_we;
  logic               load_out;

  assign s_tready = (state == S_IDLE);

  // new entry goes in at the end of the table if there is room
  assign store_we = (state == S_SCAN) && scan_res.done && !scan_res.match
                  && (count < CW'(TABLE_DEPTH));

  assign load_out = (state == S_OUT) && (!m_tvalid || m_tready);

  // axis select for the shared binning unit
  always_comb begin
    if (axis_y) begin
      bin_cfg = '{coord: hit_y, width: bin_width_y, lo: range_min_y, hi: range_max_y};
    end else begin
      bin_cfg = '{coord: hit_x, width: bin_width_x, lo: range_min_x, hi: range_max_x};
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width_x     <= RST_BIN_WIDTH;
      bin_width_y     <= RST_BIN_WIDTH;
      match_tolerance <= RST_TOLERANCE;
      range_min_x     <= RST_RANGE_MIN;
      range_max_x     <= RST_RANGE_MAX;
      range_min_y     <= RST_RANGE_MIN;
      range_max_y     <= RST_RANGE_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIN_WIDTH_X:     bin_width_x     <= cfg_data[WIDTH_W-1:0];
        REG_BIN_WIDTH_Y:     bin_width_y     <= cfg_data[WIDTH_W-1:0];
        REG_MATCH_TOLERANCE: match_tolerance <= cfg_data[WIDTH_W-1:0];
        REG_RANGE_MIN_X:     range_min_x     <= cfg_data;
        REG_RANGE_MAX_X:     range_max_x     <= cfg_data;
        REG_RANGE_MIN_Y:     range_min_y     <= cfg_data;
        REG_RANGE_MAX_Y:     range_max_y     <= cfg_data;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // sequencer: scan, store, bin x, bin y, hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      scan_start <= 1'b0;
      bin_start  <= 1'b0;
      axis_y     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // one-cycle kicks for the scan and the shared binning unit
      scan_start <= (state == S_IDLE) && s_tvalid;
      bin_start  <= ((state == S_SCAN) && scan_res.done && !scan_res.match)
                  || ((state == S_BINX) && bin_res.done);
      // output word held until taken
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            hit_x      <= s_tdata[POS_W-1:0];
            hit_y      <= s_tdata[2*POS_W-1:POS_W];
            hit_z      <= s_tdata[3*POS_W-1:2*POS_W];
            if (s_tuser[0]) begin
              count <= '0;
            end
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_res.done) begin
            if (scan_res.match) begin
              // repeat of a stored position, nothing to send
              state <= S_IDLE;
            end else begin
              full      <= !store_we;
              if (store_we) begin
                count <= count + 1'b1;
              end
              axis_y    <= 1'b0;
              state     <= S_BINX;
            end
          end
        end
        S_BINX: begin
          if (bin_res.done) begin
            bar_x     <= bin_res.bar;
            center_x  <= bin_res.center;
            axis_y    <= 1'b1;
            state     <= S_BINY;
          end
        end
        S_BINY: begin
          if (bin_res.done) begin
            bar_y    <= bin_res.bar;
            center_y <= bin_res.center;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            m_tdata <= {center_y, center_x, bar_y, bar_x, hit_z, hit_y, hit_x};
            m_tuser <= full;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  hpdb_ram #(
    .WIDTH (2 * POS_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[AW-1:0]),
    .wdata ({hit_y, hit_x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  hpdb_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .count (count),
    .hit_x (hit_x),
    .hit_y (hit_y),
    .tol   (match_tolerance),
    .raddr (raddr),
    .rdata (rdata),
    .res   (scan_res)
  );

  hpdb_bin #(
    .MAX_BINS (MAX_BINS)
  ) u_bin (
    .clk   (clk),
    .rst   (rst),
    .start (bin_start),
    .cfg   (bin_cfg),
    .res   (bin_res)
  );

  `HPDB_ASSERT_IMPL(a_store_room, store_we, count < CW'(TABLE_DEPTH), "store into a full table")
  `HPDB_ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(TABLE_DEPTH), "fill count past depth")
  `HPDB_ASSERT_IMPL(a_scan_owner, scan_res.done, state == S_SCAN, "scan finished out of turn")
  `HPDB_ASSERT_IMPL(a_bin_owner, bin_res.done, state == S_BINX || state == S_BINY, "stray bin")
  `HPDB_ASSERT_NEXT(a_out_load, load_out, m_tvalid, "loaded word not presented")

endmodule

@@ rtl/hpdb_ram.sv @@
// ---------------------------------------------------------------------------
// hpdb_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module hpdb_ram
  import hpdb_pkg::*;
#(
  parameter int WIDTH = 2 * POS_W,
  parameter int DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [addr_w(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [addr_w(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/hpdb_scan.sv @@
// ---------------------------------------------------------------------------
// hpdb_scan
// walks the stored positions one per cycle looking for a near match
// ---------------------------------------------------------------------------
module hpdb_scan
  import hpdb_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
  input  pos_t                                 hit_x,
  input  pos_t                                 hit_y,
  input  width_t                               tol,
  output logic [addr_w(TABLE_DEPTH)-1:0]       raddr,
  input  logic [2*POS_W-1:0]                   rdata,
  output scan_res_t                            res
);

  localparam int AW = addr_w(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = POS_W + 1;

  logic          busy;
  logic          pend;
  logic [CW-1:0] idx;
  logic          issue;
  logic          hit;

  pos_t                 sx;
  pos_t                 sy;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [DW-1:0]        ax;
  logic [DW-1:0]        ay;

  assign sx = rdata[POS_W-1:0];
  assign sy = rdata[2*POS_W-1:POS_W];
  assign dx = {hit_x[POS_W-1], hit_x} - {sx[POS_W-1], sx};
  assign dy = {hit_y[POS_W-1], hit_y} - {sy[POS_W-1], sy};
  assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

  // strictly inside the square on both axes
  assign hit   = pend && (ax < DW'(tol)) && (ay < DW'(tol));
  assign issue = busy && (idx < count) && !res.match && !hit;
  assign raddr = idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= 1'b0;
      idx       <= '0;
      res.done  <= 1'b0;
      res.match <= 1'b0;
    end else begin
      // finished once nothing is issued and no read is outstanding
      res.done <= busy && !start && !issue && !pend;
      if (start) begin
        busy      <= 1'b1;
        pend      <= 1'b0;
        idx       <= '0;
        res.match <= 1'b0;
      end else if (busy) begin
        pend <= issue;
        if (issue) begin
          idx <= idx + 1'b1;
        end
        if (hit) begin
          res.match <= 1'b1;
        end
        if (!issue && !pend) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/hpdb_bin.sv @@
// ---------------------------------------------------------------------------
// hpdb_bin
// bit-serial bar search with one shared add and compare, then bin centre
// ---------------------------------------------------------------------------
module hpdb_bin
  import hpdb_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  bin_cfg_t cfg,
  output bin_res_t res
);

  localparam int BAR_W = $clog2(MAX_BINS + 1);
  localparam int ACC_W = WIDTH_W + BAR_W;
  localparam int SW    = ((ACC_W > POS_W + 1) ? ACC_W : POS_W + 1) + 1;
  localparam int XW    = ((SW > CENTER_W) ? SW : CENTER_W) + 1;
  localparam int BW    = BAR_W + BAR_OUT_W;

  localparam logic signed [XW-1:0] C_MAX = XW'((64'sd1 <<< (CENTER_W - 1)) - 1);
  localparam logic signed [XW-1:0] C_MIN = XW'(-(64'sd1 <<< (CENTER_W - 1)));

  typedef enum logic [1:0] {B_IDLE, B_STEP, B_FINISH} bstate_t;

  bstate_t              state;
  logic signed [SW-1:0] diff;
  logic signed [SW-1:0] span;
  width_t               w;
  pos_t                 lo;
  logic                 below;
  logic [BAR_W-1:0]     bar;
  logic [BAR_W-1:0]     bitm;
  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     wsh;

  logic [ACC_W-1:0]     trial;
  logic [BAR_W-1:0]     trial_bar;
  logic signed [SW-1:0] trial_s;
  logic                 take;

  logic signed [XW-1:0] base;
  logic signed [XW-1:0] ctr;
  logic signed [XW-1:0] ctr_sat;
  logic [BW-1:0]        bar_ext;

  // shared unit: one add, then compare against coordinate, range and bin count
  assign trial     = acc + wsh;
  assign trial_bar = bar | bitm;
  assign trial_s   = {{(SW-ACC_W){1'b0}}, trial};
  assign take      = (trial_bar <= BAR_W'(MAX_BINS)) && (trial_s < diff) && (trial_s <= span);

  assign base = below ? -{{(XW-WIDTH_W){1'b0}}, w} : {{(XW-ACC_W){1'b0}}, acc};
  assign ctr  = {{(XW-POS_W){lo[POS_W-1]}}, lo} + base
              + {{(XW-WIDTH_W+1){1'b0}}, w[WIDTH_W-1:1]};
  assign ctr_sat = (ctr > C_MAX) ? C_MAX : ((ctr < C_MIN) ? C_MIN : ctr);
  assign bar_ext = BW'(bar);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= (state == B_FINISH);
      unique case (state)
        B_IDLE: begin
          if (start) begin
            diff  <= {{(SW-POS_W){cfg.coord[POS_W-1]}}, cfg.coord}
                   - {{(SW-POS_W){cfg.lo[POS_W-1]}}, cfg.lo};
            span  <= {{(SW-POS_W){cfg.hi[POS_W-1]}}, cfg.hi}
                   - {{(SW-POS_W){cfg.lo[POS_W-1]}}, cfg.lo};
            below <= (cfg.coord <= cfg.lo);
            w     <= cfg.width;
            lo    <= cfg.lo;
            bar   <= '0;
            acc   <= '0;
            bitm  <= {1'b1, {(BAR_W-1){1'b0}}};
            wsh   <= ACC_W'(cfg.width) << (BAR_W - 1);
            state <= B_STEP;
          end
        end
        B_STEP: begin
          if (take) begin
            bar <= trial_bar;
            acc <= trial;
          end
          wsh  <= wsh >> 1;
          bitm <= bitm >> 1;
          if (bitm[0]) begin
            state <= B_FINISH;
          end
        end
        B_FINISH: begin
          res.bar    <= below ? {BAR_OUT_W{1'b1}} : bar_ext[BAR_OUT_W-1:0];
          res.center <= ctr_sat[CENTER_W-1:0];
          state      <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
